### design/sla_pkg.sv
package sla_pkg;

    // line buffer geometry
    localparam int LINE_MAX = 32;
    localparam int ADDR_W   = $clog2(LINE_MAX);
    localparam int CNT_W    = $clog2(LINE_MAX + 1);
    localparam int CMP_W    = (CNT_W > 6) ? CNT_W : 6;

    // field widths
    localparam int MAXLEN_W  = 6;
    localparam int TICKS_W   = 16;
    localparam int CHAR_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int INDEX_W   = 5;
    localparam int LENGTH_W  = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

    // configuration reset values
    localparam logic [MAXLEN_W-1:0] MAX_LEN_RST = 6'd32;
    localparam logic [TICKS_W-1:0]  TIMEOUT_RST = 16'd1000;

    // request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BS = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

    localparam logic [TICKS_W-1:0] TICKS_SAT = '1;

    // line end reasons
    typedef enum logic [STATUS_W-1:0] {
        STAT_CR      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_TIMEOUT = 2'd2
    } t_status;

    // read-out sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CHAR,
        S_TERM
    } t_state;

    typedef struct packed {
        logic [MAXLEN_W-1:0] max_len;
        logic [TICKS_W-1:0]  timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

### design/sla_line_ram.sv
module sla_line_ram (
    input  logic                             i_clk,
    input  sla_pkg::t_ram_req                i_req,
    output logic [sla_pkg::CHAR_W-1:0]       o_rd_data
);

    logic [sla_pkg::CHAR_W-1:0] r_mem [sla_pkg::LINE_MAX];
    logic [sla_pkg::CHAR_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/sla_ctrl.sv
module sla_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sla_pkg::t_cfg                      i_cfg,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_req_type,
    input  logic [sla_pkg::CHAR_W-1:0]         i_rx_byte,
    // line store
    output sla_pkg::t_ram_req                  o_ram_req,
    input  logic [sla_pkg::CHAR_W-1:0]         i_ram_rd_data,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [sla_pkg::STATUS_W-1:0]       o_status,
    output logic [sla_pkg::CHAR_W-1:0]         o_out_char,
    output logic [sla_pkg::INDEX_W-1:0]        o_char_index,
    output logic [sla_pkg::LENGTH_W-1:0]       o_line_length,
    output logic                               o_last
);

    sla_pkg::t_state                  r_state, n_state;
    logic [sla_pkg::CNT_W-1:0]        r_count, n_count;
    logic [sla_pkg::CNT_W-1:0]        r_idx, n_idx;
    logic [sla_pkg::TICKS_W-1:0]      r_idle, n_idle;
    sla_pkg::t_status                 r_stat, n_stat;

    logic                             r_out_valid, n_out_valid;
    logic [sla_pkg::STATUS_W-1:0]     r_o_status, n_o_status;
    logic [sla_pkg::CHAR_W-1:0]       r_o_char, n_o_char;
    logic [sla_pkg::INDEX_W-1:0]      r_o_index, n_o_index;
    logic [sla_pkg::LENGTH_W-1:0]     r_o_length, n_o_length;
    logic                             r_o_last, n_o_last;

    logic                             out_free;
    logic                             in_fire;
    logic                             is_byte;
    logic                             is_cr;
    logic                             is_lf;
    logic                             is_bs;
    logic                             is_plain;
    logic [sla_pkg::CMP_W-1:0]        max_ext;
    logic [sla_pkg::CMP_W-1:0]        eff_len;
    logic [sla_pkg::CMP_W-1:0]        count_ext;
    logic [sla_pkg::CMP_W-1:0]        count_inc;
    logic [sla_pkg::CMP_W-1:0]        idx_ext;
    logic [sla_pkg::CNT_W-1:0]        idx_inc;
    logic [sla_pkg::TICKS_W-1:0]      idle_inc;
    logic                             is_full;
    logic                             is_timeout;

    // handshake
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == sla_pkg::S_IDLE) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // request decode
    assign is_byte  = (i_req_type == sla_pkg::REQ_BYTE);
    assign is_cr    = is_byte && (i_rx_byte == sla_pkg::CH_CR);
    assign is_lf    = is_byte && (i_rx_byte == sla_pkg::CH_LF);
    assign is_bs    = is_byte && (i_rx_byte == sla_pkg::CH_BS);
    assign is_plain = is_byte && !is_cr && !is_lf && !is_bs;

    // effective line size, clamped to 2..LINE_MAX
    assign max_ext = sla_pkg::CMP_W'(i_cfg.max_len);
    always_comb begin
        priority if (max_ext < sla_pkg::CMP_W'(2)) begin
            eff_len = sla_pkg::CMP_W'(2);
        end else if (max_ext > sla_pkg::CMP_W'(sla_pkg::LINE_MAX)) begin
            eff_len = sla_pkg::CMP_W'(sla_pkg::LINE_MAX);
        end else begin
            eff_len = max_ext;
        end
    end

    assign count_ext = sla_pkg::CMP_W'(r_count);
    assign count_inc = count_ext + sla_pkg::CMP_W'(1);
    assign idx_ext   = sla_pkg::CMP_W'(r_idx);
    assign idx_inc   = r_idx + sla_pkg::CNT_W'(1);
    assign is_full   = (count_inc >= eff_len - sla_pkg::CMP_W'(1));

    // idle tick counter, saturating
    assign idle_inc   = (r_idle < sla_pkg::TICKS_SAT) ? r_idle + sla_pkg::TICKS_W'(1) : r_idle;
    assign is_timeout = (idle_inc >= i_cfg.timeout_ticks);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sla_pkg::S_IDLE: begin
                if (in_fire && is_cr) begin
                    n_state = (r_count == '0) ? sla_pkg::S_TERM : sla_pkg::S_RD;
                end else if (in_fire && is_plain && is_full) begin
                    n_state = sla_pkg::S_RD;
                end
            end
            sla_pkg::S_RD: begin
                n_state = sla_pkg::S_CHAR;
            end
            sla_pkg::S_CHAR: begin
                if (out_free) begin
                    n_state = (idx_inc == r_count) ? sla_pkg::S_TERM : sla_pkg::S_RD;
                end
            end
            sla_pkg::S_TERM: begin
                if (out_free) begin
                    n_state = sla_pkg::S_IDLE;
                end
            end
            default: n_state = sla_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_idle      = r_idle;
        n_stat      = r_stat;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_status  = r_o_status;
        n_o_char    = r_o_char;
        n_o_index   = r_o_index;
        n_o_length  = r_o_length;
        n_o_last    = r_o_last;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_count[sla_pkg::ADDR_W-1:0];
        o_ram_req.wdata = i_rx_byte;
        o_ram_req.re    = 1'b0;
        o_ram_req.raddr = r_idx[sla_pkg::ADDR_W-1:0];
        unique case (r_state)
            sla_pkg::S_IDLE: begin
                if (in_fire && !is_byte) begin
                    // tick: count toward timeout
                    if (is_timeout) begin
                        n_idle      = '0;
                        n_count     = '0;
                        n_out_valid = 1'b1;
                        n_o_status  = sla_pkg::STAT_TIMEOUT;
                        n_o_char    = '0;
                        n_o_index   = '0;
                        n_o_length  = '0;
                        n_o_last    = 1'b1;
                    end else begin
                        n_idle = idle_inc;
                    end
                end else if (in_fire) begin
                    n_idle = '0;
                    n_idx  = '0;
                    if (is_cr) begin
                        n_stat = sla_pkg::STAT_CR;
                    end else if (is_bs) begin
                        if (r_count != '0) begin
                            n_count = r_count - sla_pkg::CNT_W'(1);
                        end
                    end else if (is_plain) begin
                        o_ram_req.we = 1'b1;
                        n_count      = r_count + sla_pkg::CNT_W'(1);
                        n_stat       = sla_pkg::STAT_FULL;
                    end
                end
            end
            sla_pkg::S_RD: begin
                o_ram_req.re = 1'b1;
            end
            sla_pkg::S_CHAR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_stat;
                    n_o_char    = i_ram_rd_data;
                    n_o_index   = idx_ext[sla_pkg::INDEX_W-1:0];
                    n_o_length  = '0;
                    n_o_last    = 1'b0;
                    n_idx       = idx_inc;
                end
            end
            sla_pkg::S_TERM: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_stat;
                    n_o_char    = '0;
                    n_o_index   = count_ext[sla_pkg::INDEX_W-1:0];
                    n_o_length  = count_inc[sla_pkg::LENGTH_W-1:0];
                    n_o_last    = 1'b1;
                    n_count     = '0;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_out_ready;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sla_pkg::S_IDLE;
            r_count     <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idle      <= n_idle;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_stat     <= n_stat;
        r_o_status <= n_o_status;
        r_o_char   <= n_o_char;
        r_o_index  <= n_o_index;
        r_o_length <= n_o_length;
        r_o_last   <= n_o_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_out_char    = r_o_char;
    assign o_char_index  = r_o_index;
    assign o_line_length = r_o_length;
    assign o_last        = r_o_last;

endmodule

### design/serial_line_assembler.sv
// channel   handshake                   payload
// --------  --------------------------  ----------------------------------------------
// input     i_in_valid / o_in_ready     i_req_type, i_rx_byte
// output    o_out_valid / i_out_ready   o_status, o_out_char, o_char_index,
//                                       o_line_length, o_last
// config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// a byte or tick is taken whenever the sequencer is idle and the output is free;
// after the ending byte each character of the line is read from the line store and then
// sent, in turn through the single read port of the line store, and a terminator follows.
// synchronous active-low reset clears the counters, the sequencer and the output
// valid, and loads max_len 32 and timeout_ticks 1000; the line store is not cleared.
// a stalled output holds the read-out in place; input is taken only between lines.
module serial_line_assembler (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_req_type,
    input  logic [sla_pkg::CHAR_W-1:0]            i_rx_byte,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [sla_pkg::STATUS_W-1:0]          o_status,
    output logic [sla_pkg::CHAR_W-1:0]            o_out_char,
    output logic [sla_pkg::INDEX_W-1:0]           o_char_index,
    output logic [sla_pkg::LENGTH_W-1:0]          o_line_length,
    output logic                                  o_last,
    // configuration channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sla_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sla_pkg::CFG_DAT_W-1:0]         i_cfg_data
);

    sla_pkg::t_cfg                r_cfg;
    sla_pkg::t_ram_req            ram_req;
    logic [sla_pkg::CHAR_W-1:0]   ram_rd_data;

    assign o_cfg_ready = 1'b1;

    // configuration registers, one per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len       <= sla_pkg::MAX_LEN_RST;
            r_cfg.timeout_ticks <= sla_pkg::TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sla_pkg::CFG_MAX_LEN: r_cfg.max_len <= i_cfg_data[sla_pkg::MAXLEN_W-1:0];
                sla_pkg::CFG_TIMEOUT: r_cfg.timeout_ticks <= i_cfg_data[sla_pkg::TICKS_W-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // sequencer and counters
    sla_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_rx_byte      (i_rx_byte),
        .o_ram_req      (ram_req),
        .i_ram_rd_data  (ram_rd_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_out_char     (o_out_char),
        .o_char_index   (o_char_index),
        .o_line_length  (o_line_length),
        .o_last         (o_last)
    );

    // line store
    sla_line_ram u_ram (
        .i_clk      (i_clk),
        .i_req      (ram_req),
        .o_rd_data  (ram_rd_data)
    );

endmodule
